@@ design/scpf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package scpf_pkg;

  // Queue between classifier and byte sequencer
  localparam int QueueDepth = 2;

  // APB
  localparam int AddrW = 5;
  localparam int DataW = 32;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] RegServoId    = 3'd0;
  localparam logic [2:0] RegGoalAddr   = 3'd1;
  localparam logic [2:0] RegSpeedAddr  = 3'd2;
  localparam logic [2:0] RegAccelAddr  = 3'd3;
  localparam logic [2:0] RegPosAddr    = 3'd4;

  // Register reset values
  localparam logic [7:0] ServoIdRst    = 8'd1;
  localparam logic [7:0] GoalAddrRst   = 8'd30;
  localparam logic [7:0] SpeedAddrRst  = 8'd32;
  localparam logic [7:0] AccelAddrRst  = 8'd73;
  localparam logic [7:0] PosAddrRst    = 8'd36;

  // Command modes
  localparam logic [2:0] ModeGoal   = 3'd0;
  localparam logic [2:0] ModeSpeed  = 3'd1;
  localparam logic [2:0] ModeAccel  = 3'd2;
  localparam logic [2:0] ModeRead   = 3'd3;
  localparam logic [2:0] ModePing   = 3'd4;
  localparam logic [2:0] ModeAction = 3'd5;
  localparam logic [2:0] ModeCentre = 3'd6;

  // Packet bytes
  localparam logic [7:0] HeaderByte   = 8'hFF;
  localparam logic [7:0] BroadcastId  = 8'hFE;
  localparam logic [7:0] InstPing     = 8'h01;
  localparam logic [7:0] InstRead     = 8'h02;
  localparam logic [7:0] InstWrite    = 8'h03;
  localparam logic [7:0] InstRegWrite = 8'h04;
  localparam logic [7:0] InstAction   = 8'h05;
  localparam logic [7:0] LenWord      = 8'h05;  // instr + addr + two data bytes + checksum
  localparam logic [7:0] LenByte      = 8'h04;  // instr + addr + one byte + checksum
  localparam logic [7:0] LenNone      = 8'h02;  // instr + checksum
  localparam logic [7:0] ReadCount    = 8'h02;
  localparam logic [7:0] CentreLo     = 8'h00;
  localparam logic [7:0] CentreHi     = 8'h08;

  // Body lengths (bytes between header and checksum)
  localparam logic [2:0] BodyWord = 3'd6;
  localparam logic [2:0] BodyByte = 3'd5;
  localparam logic [2:0] BodyNone = 3'd3;
  localparam int         BodyMax  = 6;

  // Value conversion: ticks = floor(512*deg/45) = (deg*GoalRecip) >> 15 for deg < 360
  localparam logic [15:0] GoalSatDeg  = 16'd360;
  localparam logic [11:0] GoalMaxTick = 12'd4095;
  localparam logic [18:0] GoalRecip   = 19'd372828;
  // speed = floor(489*v/55) = (v*SpeedRecip) >> 21 for v <= 55
  localparam logic [15:0] SpeedMaxIn  = 16'd55;
  localparam logic [24:0] SpeedRecip  = 25'd18646059;
  localparam logic [15:0] AccelMax    = 16'd254;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
    logic       rejected;
  } tx_t;

  typedef struct packed {
    logic [7:0] servo_id;
    logic [7:0] goal_address;
    logic [7:0] speed_address;
    logic [7:0] accel_address;
    logic [7:0] position_address;
  } cfg_t;

  typedef struct packed {
    logic                     rejected;
    logic [2:0]               body_len;
    logic [BodyMax-1:0][7:0]  body;
  } desc_t;

endpackage

`default_nettype wire

@@ design/servo_command_packet_framer.sv @@
// Path: a command is written into the descriptor queue, and the first byte of its
//   packet then goes from the queue head into the tx register.
// Throughput: one byte per cycle from the back sequencer unless tx_stall holds it;
//   a packet is 9 bytes goal/speed/centre, 8 accel/read, 6 ping/action, a refusal 1.
//   Commands are taken every cycle while the descriptor queue (QueueDepth) has room.
// Reset: synchronous, active high; empties the queue, drops tx_valid, and loads the
//   register defaults (id 1, goal 30, speed 32, accel 73, position 36).
`timescale 1ns / 1ps
`default_nettype none

module servo_command_packet_framer #(
  parameter int QueueDepth = scpf_pkg::QueueDepth
) (
  input  wire                          clk,
  input  wire                          rst,
  // command channel
  input  wire                          cmd_valid,
  output logic                         cmd_stall,
  input  wire  scpf_pkg::cmd_t         cmd,
  // byte channel
  output logic                         tx_valid,
  input  wire                          tx_stall,
  output scpf_pkg::tx_t                tx,
  // APB register port
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [scpf_pkg::AddrW-1:0]   paddr,
  input  wire  [scpf_pkg::DataW-1:0]   pwdata,
  output logic [scpf_pkg::DataW-1:0]   prdata,
  output logic                         pready
);

  // Register file: five bytes at word indexes paddr[4:2]; other indexes ignored on write,
  // read as zero.
  scpf_pkg::cfg_t  cfg;
  logic            reg_wr;
  logic [2:0]      reg_idx;

  // Front to queue
  scpf_pkg::desc_t front_desc;
  logic            q_full;

  // Queue to back
  scpf_pkg::desc_t head;
  logic            head_valid;
  logic            head_pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.servo_id         <= scpf_pkg::ServoIdRst;
      cfg.goal_address     <= scpf_pkg::GoalAddrRst;
      cfg.speed_address    <= scpf_pkg::SpeedAddrRst;
      cfg.accel_address    <= scpf_pkg::AccelAddrRst;
      cfg.position_address <= scpf_pkg::PosAddrRst;
    end else if (reg_wr) begin
      unique case (reg_idx)
        scpf_pkg::RegServoId:   cfg.servo_id         <= pwdata[7:0];
        scpf_pkg::RegGoalAddr:  cfg.goal_address     <= pwdata[7:0];
        scpf_pkg::RegSpeedAddr: cfg.speed_address    <= pwdata[7:0];
        scpf_pkg::RegAccelAddr: cfg.accel_address    <= pwdata[7:0];
        scpf_pkg::RegPosAddr:   cfg.position_address <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      scpf_pkg::RegServoId:   prdata = 32'(cfg.servo_id);
      scpf_pkg::RegGoalAddr:  prdata = 32'(cfg.goal_address);
      scpf_pkg::RegSpeedAddr: prdata = 32'(cfg.speed_address);
      scpf_pkg::RegAccelAddr: prdata = 32'(cfg.accel_address);
      scpf_pkg::RegPosAddr:   prdata = 32'(cfg.position_address);
      default:                prdata = '0;
    endcase
  end

  // Front: range checks, unit conversion and body bytes, straight into the queue.
  scpf_front u_front (
    .cmd  (cmd),
    .cfg  (cfg),
    .desc (front_desc)
  );

  // Stall only on a full queue, so a waiting tx byte never blocks intake.
  assign cmd_stall = q_full;

  scpf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cmd_valid),
    .wr_desc  (front_desc),
    .full     (q_full),
    .rd_valid (head_valid),
    .rd_desc  (head),
    .rd_pop   (head_pop)
  );

  // Back: header, body, running checksum; one byte per cycle into tx unless stalled.
  scpf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .tx_valid   (tx_valid),
    .tx_stall   (tx_stall),
    .tx         (tx)
  );

endmodule

`default_nettype wire

@@ design/scpf_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module scpf_front (
  input  wire  scpf_pkg::cmd_t  cmd,
  input  wire  scpf_pkg::cfg_t  cfg,
  output scpf_pkg::desc_t       desc
);

  logic [27:0] goal_prod;
  logic [30:0] speed_prod;
  logic [11:0] goal_ticks;
  logic [8:0]  speed_ticks;

  assign goal_prod  = 28'(cmd.value[8:0]) * 28'(scpf_pkg::GoalRecip);
  assign speed_prod = 31'(cmd.value[5:0]) * 31'(scpf_pkg::SpeedRecip);

  // saturation: 360 deg and above give 4096 or more ticks
  assign goal_ticks  = (cmd.value >= scpf_pkg::GoalSatDeg) ? scpf_pkg::GoalMaxTick
                                                          : goal_prod[26:15];
  assign speed_ticks = speed_prod[29:21];

  always_comb begin
    desc          = '0;
    desc.body[0]  = cfg.servo_id;
    unique case (cmd.mode)
      scpf_pkg::ModeGoal: begin
        desc.body_len = scpf_pkg::BodyWord;
        desc.body[1]  = scpf_pkg::LenWord;
        desc.body[2]  = scpf_pkg::InstRegWrite;
        desc.body[3]  = cfg.goal_address;
        desc.body[4]  = goal_ticks[7:0];
        desc.body[5]  = {4'b0, goal_ticks[11:8]};
      end
      scpf_pkg::ModeSpeed: begin
        desc.rejected = (cmd.value > scpf_pkg::SpeedMaxIn);
        desc.body_len = scpf_pkg::BodyWord;
        desc.body[1]  = scpf_pkg::LenWord;
        desc.body[2]  = scpf_pkg::InstWrite;
        desc.body[3]  = cfg.speed_address;
        desc.body[4]  = speed_ticks[7:0];
        desc.body[5]  = {7'b0, speed_ticks[8]};
      end
      scpf_pkg::ModeAccel: begin
        desc.rejected = (cmd.value > scpf_pkg::AccelMax);
        desc.body_len = scpf_pkg::BodyByte;
        desc.body[1]  = scpf_pkg::LenByte;
        desc.body[2]  = scpf_pkg::InstWrite;
        desc.body[3]  = cfg.accel_address;
        desc.body[4]  = cmd.value[7:0];
      end
      scpf_pkg::ModeRead: begin
        desc.body_len = scpf_pkg::BodyByte;
        desc.body[1]  = scpf_pkg::LenByte;
        desc.body[2]  = scpf_pkg::InstRead;
        desc.body[3]  = cfg.position_address;
        desc.body[4]  = scpf_pkg::ReadCount;
      end
      scpf_pkg::ModePing: begin
        desc.body_len = scpf_pkg::BodyNone;
        desc.body[1]  = scpf_pkg::LenNone;
        desc.body[2]  = scpf_pkg::InstPing;
      end
      scpf_pkg::ModeAction: begin
        desc.body_len = scpf_pkg::BodyNone;
        desc.body[0]  = scpf_pkg::BroadcastId;
        desc.body[1]  = scpf_pkg::LenNone;
        desc.body[2]  = scpf_pkg::InstAction;
      end
      scpf_pkg::ModeCentre: begin
        desc.body_len = scpf_pkg::BodyWord;
        desc.body[1]  = scpf_pkg::LenWord;
        desc.body[2]  = scpf_pkg::InstRegWrite;
        desc.body[3]  = cfg.goal_address;
        desc.body[4]  = scpf_pkg::CentreLo;
        desc.body[5]  = scpf_pkg::CentreHi;
      end
      default: begin
        desc.rejected = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/scpf_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module scpf_queue #(
  parameter int Depth = scpf_pkg::QueueDepth
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    wr_valid,
  input  wire  scpf_pkg::desc_t  wr_desc,
  output logic                   full,
  output logic                   rd_valid,
  output scpf_pkg::desc_t        rd_desc,
  input  wire                    rd_pop
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  scpf_pkg::desc_t entry [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;

  assign full     = (count == CntW'(Depth));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && !full;
  assign rd_desc  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, rd_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/scpf_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module scpf_back (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    head_valid,
  input  wire  scpf_pkg::desc_t  head,
  output logic                   head_pop,
  output logic                   tx_valid,
  input  wire                    tx_stall,
  output scpf_pkg::tx_t          tx
);

  logic [3:0] pos;      // byte position within packet
  logic [7:0] sum;      // running sum of body bytes sent so far
  logic       advance;
  logic       final_byte;
  logic       is_body;
  logic [7:0] byte_sel;

  assign advance    = head_valid && (!tx_valid || !tx_stall);
  assign final_byte = head.rejected || (pos == 4'(head.body_len) + 4'd2);
  assign is_body    = !head.rejected && (pos >= 4'd2) && !final_byte;
  assign head_pop   = advance && final_byte;

  always_comb begin
    if (head.rejected) begin
      byte_sel = 8'h00;
    end else if (pos < 4'd2) begin
      byte_sel = scpf_pkg::HeaderByte;
    end else if (final_byte) begin
      byte_sel = ~sum;
    end else begin
      byte_sel = head.body[3'(pos - 4'd2)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
      pos      <= '0;
      sum      <= '0;
    end else begin
      if (!tx_valid || !tx_stall) begin
        tx_valid <= head_valid;
      end
      if (advance) begin
        pos <= final_byte ? 4'd0 : pos + 4'd1;
        if (final_byte) begin
          sum <= '0;
        end else if (is_body) begin
          sum <= sum + byte_sel;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tx.tx_byte  <= byte_sel;
      tx.last     <= final_byte;
      tx.rejected <= head.rejected;
    end
  end

endmodule

`default_nettype wire

@@ design/scpf_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module scpf_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  tx_valid,
  input wire                  tx_stall,
  input wire scpf_pkg::tx_t   tx,
  input wire                  pready
);

  // stalled item holds
  a_tx_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_stall |=> tx_valid && $stable(tx))
    else $error("tx item changed while stalled");

  // a refusal is a lone zero byte
  a_reject_form: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx.rejected |-> tx.last && (tx.tx_byte == 8'h00))
    else $error("refusal item malformed");

  // a packet runs on without gaps or a refusal inside it
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_stall && !tx.last |=> tx_valid && !tx.rejected)
    else $error("packet broken after non-final byte");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !tx_valid)
    else $error("tx_valid not cleared by reset");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

endmodule

bind servo_command_packet_framer scpf_checker u_scpf_checker (
  .clk      (clk),
  .rst      (rst),
  .tx_valid (tx_valid),
  .tx_stall (tx_stall),
  .tx       (tx),
  .pready   (pready)
);

`default_nettype wire

@@ sim/servo_command_packet_framer_tb.sv @@
`timescale 1ns / 1ps

module servo_command_packet_framer_tb;
  import scpf_pkg::*;

  // mode 7 has no name in the package; the block must refuse it
  localparam logic [2:0] ModeSpare = 3'd7;
  // register indexes past the end of the map; writes there must change nothing
  localparam logic [2:0] RegFirstSpare = 3'd5;
  localparam logic [2:0] RegLastSpare  = 3'd7;
  localparam int NumDirected = 23;
  localparam int RandomPerSetting = 50;

  logic clk;
  logic rst = 1'b1;

  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;

  logic tx_valid;
  logic tx_stall = 1'b0;
  tx_t  tx;

  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  servo_command_packet_framer dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .tx_valid (tx_valid),
    .tx_stall (tx_stall),
    .tx       (tx),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Directed table. A refuse row expects the single refusal item; any other row with
  // n set carries the packet typed in by hand (reset settings, extremes); anything
  // else goes through the packet predictor.
  typedef struct packed {
    logic [2:0]       mode;
    logic [15:0]      value;
    logic             refuse;
    logic [3:0]       n;
    logic [0:8][7:0]  pkt;
  } row_t;

  row_t directed [NumDirected] = '{
    '{ModePing,   16'h0000, 1'b0, 4'd6, 72'hFFFF_0102_01FB_0000_00},
    '{ModeAction, 16'hFFFF, 1'b0, 4'd6, 72'hFFFF_FE02_05FA_0000_00},
    '{ModeCentre, 16'h0000, 1'b0, 4'd9, 72'hFFFF_0105_041E_0008_CF},
    '{ModeRead,   16'hFFFF, 1'b0, 4'd8, 72'hFFFF_0104_0224_02D2_00},
    '{ModeGoal,   16'h0000, 1'b0, 4'd9, 72'hFFFF_0105_041E_0000_D7},
    // far past 360 degrees: saturates at the top tick
    '{ModeGoal,   16'hFFFF, 1'b0, 4'd9, 72'hFFFF_0105_041E_FF0F_C9},
    // either side of the saturation point, and half travel
    '{ModeGoal,   16'd359,  1'b0, 4'd0, 72'h0},
    '{ModeGoal,   16'd360,  1'b0, 4'd0, 72'h0},
    '{ModeGoal,   16'd180,  1'b0, 4'd0, 72'h0},
    '{ModeSpeed,  16'd0,    1'b0, 4'd9, 72'hFFFF_0105_0320_0000_D6},
    '{ModeSpeed,  16'd55,   1'b0, 4'd9, 72'hFFFF_0105_0320_E901_EC},
    // speed too large, then small speed and acceleration values
    '{ModeSpeed,  16'd56,   1'b1, 4'd1, 72'h0},
    '{ModeSpeed,  16'hFFFF, 1'b1, 4'd1, 72'h0},
    '{ModeSpeed,  16'd1,    1'b0, 4'd0, 72'h0},
    '{ModeAccel,  16'd0,    1'b0, 4'd0, 72'h0},
    '{ModeAccel,  16'd254,  1'b0, 4'd8, 72'hFFFF_0104_0349_FEB0_00},
    // acceleration too large
    '{ModeAccel,  16'd255,  1'b1, 4'd1, 72'h0},
    '{ModeAccel,  16'hFFFF, 1'b1, 4'd1, 72'h0},
    // unused mode
    '{ModeSpare,  16'h0000, 1'b1, 4'd1, 72'h0},
    '{ModeSpare,  16'hFFFF, 1'b1, 4'd1, 72'h0},
    // operand ignored by modes without one
    '{ModePing,   16'hAAAA, 1'b0, 4'd0, 72'h0},
    '{ModeCentre, 16'h5555, 1'b0, 4'd0, 72'h0},
    '{ModeAction, 16'h0000, 1'b0, 4'd0, 72'h0}
  };

  // predictor copy of the register file, and bytes still owed by the block
  cfg_t cfg_model = '{ServoIdRst, GoalAddrRst, SpeedAddrRst, AccelAddrRst, PosAddrRst};
  tx_t  expected_tx [$];

  int errors = 0;
  int cmds_sent = 0;
  int bytes_seen = 0;
  int refusals_seen = 0;
  int settings_used = 1;
  int stall_hold = 0;

  // append one owed byte to the tail of the expected list
  function automatic void owe_item(tx_t t);
    expected_tx.insert(expected_tx.size(), t);
  endfunction

  // Work out the bytes one command should produce and queue them.
  function automatic void frame_command(cmd_t c);
    logic [7:0]  body [6];
    logic [31:0] ticks;
    logic [7:0]  sum;
    int n;
    n = 0;
    sum = '0;
    body = '{default: 8'h00};
    case (c.mode)
      ModeGoal: begin
        ticks = (32'd2048 * c.value) / 32'd180;
        if (ticks > 32'(GoalMaxTick)) ticks = 32'(GoalMaxTick);
        body = '{cfg_model.servo_id, LenWord, InstRegWrite, cfg_model.goal_address,
                 ticks[7:0], ticks[15:8]};
        n = 6;
      end
      ModeSpeed: begin
        ticks = (32'd489 * c.value) / 32'd55;
        if (ticks <= 32'd489) begin
          body = '{cfg_model.servo_id, LenWord, InstWrite, cfg_model.speed_address,
                   ticks[7:0], ticks[15:8]};
          n = 6;
        end
      end
      ModeAccel: begin
        if (c.value <= AccelMax) begin
          body = '{cfg_model.servo_id, LenByte, InstWrite, cfg_model.accel_address,
                   c.value[7:0], 8'h00};
          n = 5;
        end
      end
      ModeRead: begin
        body = '{cfg_model.servo_id, LenByte, InstRead, cfg_model.position_address,
                 ReadCount, 8'h00};
        n = 5;
      end
      ModePing: begin
        body = '{cfg_model.servo_id, LenNone, InstPing, 8'h00, 8'h00, 8'h00};
        n = 3;
      end
      ModeAction: begin
        body = '{BroadcastId, LenNone, InstAction, 8'h00, 8'h00, 8'h00};
        n = 3;
      end
      ModeCentre: begin
        body = '{cfg_model.servo_id, LenWord, InstRegWrite, cfg_model.goal_address,
                 CentreLo, CentreHi};
        n = 6;
      end
      default: ;
    endcase
    if (n == 0) begin
      owe_item(tx_t'{8'h00, 1'b1, 1'b1});
      return;
    end
    owe_item(tx_t'{HeaderByte, 1'b0, 1'b0});
    owe_item(tx_t'{HeaderByte, 1'b0, 1'b0});
    for (int i = 0; i < n; i++) begin
      owe_item(tx_t'{body[i], 1'b0, 1'b0});
      sum += body[i];
    end
    owe_item(tx_t'{~sum, 1'b1, 1'b0});
  endfunction

  // Offer one command: random gap with valid low, then hold until taken.
  // Every 40 commands there is a stretch of ten back-to-back.
  task automatic send_command(cmd_t c);
    int gap;
    gap = (cmds_sent % 40 >= 30) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (cmd_stall);
    cmds_sent++;
  endtask

  // Mostly values near the interesting ranges, one in four fully random.
  function automatic cmd_t random_command();
    cmd_t c;
    int sel;
    c.mode = 3'($urandom_range(0, 7));
    sel = $urandom_range(0, 3);
    c.value = 16'($urandom);
    if (sel != 0) begin
      case (c.mode)
        ModeGoal:  c.value = 16'($urandom_range(0, 400));
        ModeSpeed: c.value = 16'($urandom_range(0, 70));
        ModeAccel: c.value = 16'($urandom_range(0, 300));
        default: ;
      endcase
    end
    return c;
  endfunction

  task automatic run_random(int count);
    cmd_t c;
    for (int i = 0; i < count; i++) begin
      c = random_command();
      send_command(c);
      frame_command(c);
    end
  endtask

  // Stop offering, let every owed byte out, then wait on the clock.
  task automatic drain();
    cmd_valid <= 1'b0;
    while (expected_tx.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'({idx, 2'b00});
    pwdata <= {24'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      RegServoId:   cfg_model.servo_id = val;
      RegGoalAddr:  cfg_model.goal_address = val;
      RegSpeedAddr: cfg_model.speed_address = val;
      RegAccelAddr: cfg_model.accel_address = val;
      RegPosAddr:   cfg_model.position_address = val;
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_check(logic [2:0] idx, logic [7:0] want);
    logic [7:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= AddrW'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata[7:0];
    if (got !== want) begin
      $display("%0t: register %0d read expected %h actual %h", $time, idx, want, got);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Program a full setting, poke a spare index, then read the map back.
  task automatic apply_setting(logic [7:0] id, logic [7:0] ga, logic [7:0] sa,
                               logic [7:0] aa, logic [7:0] pa);
    reg_write(RegServoId, id);
    reg_write(RegGoalAddr, ga);
    reg_write(RegSpeedAddr, sa);
    reg_write(RegAccelAddr, aa);
    reg_write(RegPosAddr, pa);
    reg_write(3'($urandom_range(RegFirstSpare, RegLastSpare)), 8'($urandom));
    reg_check(RegServoId, cfg_model.servo_id);
    reg_check(RegGoalAddr, cfg_model.goal_address);
    reg_check(RegSpeedAddr, cfg_model.speed_address);
    reg_check(RegAccelAddr, cfg_model.accel_address);
    reg_check(RegPosAddr, cfg_model.position_address);
    settings_used++;
  endtask

  // Byte sink: check each taken item against the oldest owed byte, then draw
  // how long to stall next. Every 64 bytes there is a stretch of 16 unstalled.
  always @(posedge clk) begin
    tx_t want;
    if (!rst && tx_valid && !tx_stall) begin
      bytes_seen++;
      if (tx.rejected) refusals_seen++;
      if (expected_tx.size() == 0) begin
        $display("%0t: unexpected item byte %h last %b rejected %b", $time,
                 tx.tx_byte, tx.last, tx.rejected);
        errors++;
      end else begin
        want = expected_tx.pop_front();
        if (tx.tx_byte !== want.tx_byte) begin
          $display("%0t: tx_byte expected %h actual %h", $time, want.tx_byte, tx.tx_byte);
          errors++;
        end
        if (tx.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, tx.last);
          errors++;
        end
        if (tx.rejected !== want.rejected) begin
          $display("%0t: rejected expected %b actual %b", $time, want.rejected,
                   tx.rejected);
          errors++;
        end
      end
      stall_hold = (bytes_seen % 64 >= 48) ? 0 : $urandom_range(0, 11);
    end
    if (stall_hold != 0) begin
      tx_stall <= 1'b1;
      stall_hold--;
    end else begin
      tx_stall <= 1'b0;
    end
  end

  initial begin
    row_t r;
    cmd_t c;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pass at reset settings
    for (int i = 0; i < NumDirected; i++) begin
      r = directed[i];
      c = '{mode: r.mode, value: r.value};
      send_command(c);
      if (r.refuse) begin
        owe_item(tx_t'{8'h00, 1'b1, 1'b1});
      end else if (r.n != 0) begin
        for (int k = 0; k < r.n; k++)
          owe_item(tx_t'{r.pkt[k], k == int'(r.n) - 1, 1'b0});
      end else begin
        frame_command(c);
      end
    end
    run_random(RandomPerSetting);

    // all-zero and all-ones settings, then the broadcast id, then a random id below it
    drain();
    apply_setting(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    run_random(RandomPerSetting);
    drain();
    apply_setting(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_random(RandomPerSetting);
    drain();
    apply_setting(8'hFE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_random(RandomPerSetting);
    drain();
    apply_setting(8'($urandom_range(0, 253)), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom));
    run_random(RandomPerSetting);

    drain();
    repeat (10) @(posedge clk);

    $display("Sent %0d commands across %0d register settings;", cmds_sent, settings_used);
    $display("checked %0d output bytes, %0d of them refusals.", bytes_seen, refusals_seen);
    if (errors == 0 && expected_tx.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
